[design/cut_dominance_filter_assert.svh]
// Assertion macros used by the cut dominance filter checker.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef CUT_DOMINANCE_FILTER_ASSERT_SVH
`define CUT_DOMINANCE_FILTER_ASSERT_SVH

// Check a consequence in the same cycle as its trigger
`define CDF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its trigger
`define CDF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/cdf_pkg.sv]
// Shared sizes and types for the cut dominance filter.
// Depends on nothing; used by the top level.
`default_nettype none

package cdf_pkg;

	// Store and cut dimensions
	localparam int MAX_KEPT   = 64;
	localparam int MAX_LEAVES = 6;
	localparam int LEAF_BITS  = 24;

	// Fixed port geometry (LEAF_BITS must not exceed LEAF_W)
	localparam int IN_LEAVES  = 6;
	localparam int LEAF_W     = 24;
	localparam int LCNT_W     = 3;

	// Derived widths
	localparam int CNT_W = $clog2(MAX_LEAVES + 1);
	localparam int IDX_W = $clog2(MAX_KEPT);
	localparam int TOT_W = $clog2(MAX_KEPT + 1);

	typedef logic [MAX_LEAVES-1:0][LEAF_BITS-1:0] leaf_vec_t;

	// One stored cut: leaf count and leaf ids
	typedef struct packed {
		logic [CNT_W-1:0] size;
		leaf_vec_t        leaves;
	} row_t;

	localparam int ROW_W = $bits(row_t);

endpackage

`default_nettype wire

[design/cdf_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module cdf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[design/cut_dominance_filter.sv]
// Cut dominance filter top level: scans the kept-cut store and decides keep or drop.
// Depends on cdf_pkg and cdf_ram.
//
//   channel   handshake            payload
//   input     start / busy         first_of_list, leaf_count, leaf_0 .. leaf_5
//   result    done (one cycle)     keep, store_full
//
// A first cut of a list gives its result in the cycle after it is taken.
// Any other cut reads one stored cut per cycle through the single read port of
// the store, and the scan ends early when a dominating cut turns up.
// Reset clears the stored-cut count but not the store; the store itself has no clearing pass.
// The result is registered, so the next item may be taken while done is high;
// the receiver cannot stall.
`default_nettype none

module cut_dominance_filter (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output      logic                        busy,
	input  wire logic                        first_of_list,
	input  wire logic [cdf_pkg::LCNT_W-1:0]  leaf_count,
	input  wire logic [cdf_pkg::LEAF_W-1:0]  leaf_0,
	input  wire logic [cdf_pkg::LEAF_W-1:0]  leaf_1,
	input  wire logic [cdf_pkg::LEAF_W-1:0]  leaf_2,
	input  wire logic [cdf_pkg::LEAF_W-1:0]  leaf_3,
	input  wire logic [cdf_pkg::LEAF_W-1:0]  leaf_4,
	input  wire logic [cdf_pkg::LEAF_W-1:0]  leaf_5,
	output      logic                        done,
	output      logic                        keep,
	output      logic                        store_full
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t                         state_q;
	logic [cdf_pkg::TOT_W-1:0]      total_q;
	logic [cdf_pkg::TOT_W-1:0]      issue_q;
	logic                           valid_s1;
	logic                           hit_q;
	cdf_pkg::leaf_vec_t             cut_q;
	logic [cdf_pkg::CNT_W-1:0]      cnt_q;
	logic                           done_q;
	logic                           keep_q;
	logic                           full_q;

	logic [cdf_pkg::IN_LEAVES-1:0][cdf_pkg::LEAF_W-1:0] port_leaves;
	cdf_pkg::leaf_vec_t             in_leaves;
	logic [cdf_pkg::CNT_W-1:0]      in_cnt;
	logic                           accept;
	logic                           scan_end;
	logic                           rd_en;
	logic                           wr_en;
	logic                           dom;
	logic                           store_at_max;
	cdf_pkg::row_t                  rd_row;
	cdf_pkg::row_t                  wr_row;
	logic [cdf_pkg::ROW_W-1:0]      rd_bits;

	assign port_leaves = {leaf_5, leaf_4, leaf_3, leaf_2, leaf_1, leaf_0};

	// Mask leaf ids and saturate the count
	always_comb begin
		for (int i = 0; i < cdf_pkg::MAX_LEAVES; i++) begin
			in_leaves[i] = port_leaves[i][cdf_pkg::LEAF_BITS-1:0];
		end
		if (leaf_count > cdf_pkg::LCNT_W'(cdf_pkg::MAX_LEAVES)) begin
			in_cnt = cdf_pkg::CNT_W'(cdf_pkg::MAX_LEAVES);
		end else begin
			in_cnt = cdf_pkg::CNT_W'(leaf_count);
		end
	end

	assign accept       = start && !busy;
	assign scan_end     = (issue_q == total_q);
	assign rd_en        = (state_q == ST_SCAN) && !scan_end;
	assign store_at_max = (total_q == cdf_pkg::TOT_W'(cdf_pkg::MAX_KEPT));
	assign wr_en        = (state_q == ST_FINISH) && !hit_q && !store_at_max;
	assign wr_row       = '{size: cnt_q, leaves: cut_q};
	assign rd_row       = cdf_pkg::row_t'(rd_bits);

	// Stored cut dominates when it is smaller and each of its leaves is in the cut
	always_comb begin
		logic all_found;
		logic found;
		all_found = 1'b1;
		for (int i = 0; i < cdf_pkg::MAX_LEAVES; i++) begin
			found = (i >= int'(rd_row.size));
			for (int k = 0; k < cdf_pkg::MAX_LEAVES; k++) begin
				if (k < int'(cnt_q) && cut_q[k] == rd_row.leaves[i]) begin
					found = 1'b1;
				end
			end
			all_found = all_found && found;
		end
		dom = valid_s1 && (rd_row.size < cnt_q) && all_found;
	end

	cdf_ram #(
		.WIDTH(cdf_pkg::ROW_W),
		.DEPTH(cdf_pkg::MAX_KEPT)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(total_q[cdf_pkg::IDX_W-1:0]),
		.wdata(wr_row),
		.re   (rd_en),
		.raddr(issue_q[cdf_pkg::IDX_W-1:0]),
		.rdata(rd_bits)
	);

	// Sequencer: hold the cut, scan the store, decide and append
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			total_q  <= '0;
			issue_q  <= '0;
			valid_s1 <= 1'b0;
			hit_q    <= 1'b0;
			done_q   <= 1'b0;
			keep_q   <= 1'b0;
			full_q   <= 1'b0;
		end else begin
			done_q   <= 1'b0;
			valid_s1 <= rd_en;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (first_of_list) begin
							total_q <= '0;
							done_q  <= 1'b1;
							keep_q  <= 1'b1;
							full_q  <= 1'b0;
						end else begin
							issue_q <= '0;
							hit_q   <= 1'b0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						issue_q <= issue_q + 1'b1;
					end
					// Drop at the first dominating cut, else finish after the last read
					if (dom) begin
						hit_q    <= 1'b1;
						valid_s1 <= 1'b0;
						state_q  <= ST_FINISH;
					end else if (scan_end) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					done_q  <= 1'b1;
					keep_q  <= !hit_q;
					full_q  <= !hit_q && store_at_max;
					if (wr_en) begin
						total_q <= total_q + 1'b1;
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Load the cut on acceptance
	always_ff @(posedge clk) begin
		if (accept) begin
			cut_q <= in_leaves;
			cnt_q <= in_cnt;
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign keep       = keep_q;
	assign store_full = full_q;

endmodule

`default_nettype wire

[design/cdf_checker.sv]
// Port-level checker for the cut dominance filter, bound to the top level.
// Depends on cut_dominance_filter_assert.svh.
`default_nettype none

`include "cut_dominance_filter_assert.svh"

module cdf_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       start,
	input wire logic                       busy,
	input wire logic                       first_of_list,
	input wire logic                       done,
	input wire logic                       keep,
	input wire logic                       store_full
);

	logic take_first;
	logic take_other;

	assign take_first = start && !busy && first_of_list;
	assign take_other = start && !busy && !first_of_list;

	// A full store is only reported for a kept item
	`CDF_ASSERT_NOW(a_full_only_kept, done && store_full, keep, "store_full without keep")

	// A first cut is kept, unstored, in the next cycle
	`CDF_ASSERT_NEXT(a_first_result, take_first, done && keep && !store_full, "first cut result wrong")

	// Any other cut starts a scan
	`CDF_ASSERT_NEXT(a_scan_starts, take_other, busy && !done, "scan did not start")

	// A result follows either a scan or a first cut
	`CDF_ASSERT_NOW(a_done_origin, done, $past(busy) || $past(take_first), "result without item")

endmodule

bind cut_dominance_filter cdf_checker u_cdf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.first_of_list(first_of_list),
	.done         (done),
	.keep         (keep),
	.store_full   (store_full)
);

`default_nettype wire
